[hdl/prefix_code_tree_decoder_top_defines.svh]
// Assertion macros for the prefix-code tree decoder.
// Included by the top level; depends on signals clk and rst_n in the including scope.
`ifndef PREFIX_CODE_TREE_DECODER_TOP_DEFINES_SVH
`define PREFIX_CODE_TREE_DECODER_TOP_DEFINES_SVH

// Check a property on every clock edge outside reset
`define PCTD_CHECK(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check an implication on every clock edge outside reset
`define PCTD_CHECK_IMP(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// Check an implication in the next cycle, outside reset
`define PCTD_CHECK_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

[hdl/pctd_pkg.sv]
// Shared types and constants of the prefix-code tree decoder.
// No dependencies; imported by the core and the top level.
package pctd_pkg;

    // Preorder byte that marks an internal node
    localparam logic [7:0] SYM_INTERNAL = 8'd42;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_DECODE = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_DECODED    = 3'd1,
        ST_INCOMPLETE = 3'd2,
        ST_MISSING    = 3'd3,
        ST_OVERFLOW   = 3'd4
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    // Control from the handshake sequencer to the core
    typedef struct packed {
        logic       issue;
        logic       commit;
        cmd_t       cmd;
        logic [7:0] sym;
        logic       code_bit;
    } pctd_ctl_t;

    // Result from the core
    typedef struct packed {
        status_t    status;
        logic [7:0] symbol;
    } pctd_res_t;

endpackage

[hdl/pctd_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; read data holds while rd_en is low.
module pctd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[hdl/pctd_core.sv]
// Tree store, pending-node stack and decode walker of the prefix-code tree decoder.
// Depends on pctd_pkg and pctd_ram.
module pctd_core
    import pctd_pkg::*;
#(
    parameter int MAX_NODES   = 256,
    parameter int STACK_DEPTH = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    input  pctd_ctl_t ctl,
    output pctd_res_t res
);

    localparam int NODE_W  = $clog2(MAX_NODES);
    localparam int CNT_W   = $clog2(MAX_NODES + 1);
    localparam int SP_W    = $clog2(STACK_DEPTH);
    localparam int LVL_W   = $clog2(STACK_DEPTH + 1);
    localparam int CHILD_W = NODE_W + 8;
    localparam int STK_W   = NODE_W + 1;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_NODES);
    localparam logic [LVL_W-1:0] LVL_MAX = LVL_W'(STACK_DEPTH);

    // Architectural state; the top of the pending stack lives in registers
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [LVL_W-1:0]  level_reg, level_next;
    logic [NODE_W-1:0] cur_reg, cur_next;
    logic [NODE_W-1:0] top_node_reg, top_node_next;
    logic              top_ldone_reg, top_ldone_next;
    logic [7:0]        root_sym_reg, root_sym_next;

    // Memory ports
    logic               left_we, right_we, stk_we;
    logic [NODE_W-1:0]  child_waddr;
    logic [CHILD_W-1:0] child_wdata;
    logic [CHILD_W-1:0] left_rdata, right_rdata, child_sel;
    logic [SP_W-1:0]    stk_waddr;
    logic [STK_W-1:0]   stk_wdata, stk_rdata;

    logic [LVL_W-1:0]  lvl_m1, lvl_m2, after;
    logic [NODE_W-1:0] idx;
    logic              tree_done, is_star, stack_full;

    assign lvl_m1    = level_reg - LVL_W'(1);
    assign lvl_m2    = level_reg - LVL_W'(2);
    assign idx       = count_reg[NODE_W-1:0];
    assign tree_done = (count_reg != '0) && (level_reg == '0);
    assign is_star   = (ctl.sym == SYM_INTERNAL);
    assign after     = (level_reg != '0 && top_ldone_reg) ? lvl_m1 : level_reg;
    assign stack_full = is_star && (after >= LVL_MAX);
    assign child_sel = ctl.code_bit ? right_rdata : left_rdata;

    // Child entries hold {child symbol, child index} so a decode step needs one read
    pctd_ram #(.WIDTH(CHILD_W), .DEPTH(MAX_NODES)) u_left_ram (
        .clk     (clk),
        .wr_en   (left_we),
        .wr_addr (child_waddr),
        .wr_data (child_wdata),
        .rd_en   (ctl.issue),
        .rd_addr (cur_reg),
        .rd_data (left_rdata)
    );

    pctd_ram #(.WIDTH(CHILD_W), .DEPTH(MAX_NODES)) u_right_ram (
        .clk     (clk),
        .wr_en   (right_we),
        .wr_addr (child_waddr),
        .wr_data (child_wdata),
        .rd_en   (ctl.issue),
        .rd_addr (cur_reg),
        .rd_data (right_rdata)
    );

    // Entries below the cached top; the next top is fetched ahead for a pop
    pctd_ram #(.WIDTH(STK_W), .DEPTH(STACK_DEPTH)) u_stack_ram (
        .clk     (clk),
        .wr_en   (stk_we),
        .wr_addr (stk_waddr),
        .wr_data (stk_wdata),
        .rd_en   (ctl.issue),
        .rd_addr (lvl_m2[SP_W-1:0]),
        .rd_data (stk_rdata)
    );

    // Evaluate the held word against the state and the fetched entries
    always_comb
    begin
        count_next     = count_reg;
        level_next     = level_reg;
        cur_next       = cur_reg;
        top_node_next  = top_node_reg;
        top_ldone_next = top_ldone_reg;
        root_sym_next  = root_sym_reg;
        left_we        = 1'b0;
        right_we       = 1'b0;
        stk_we         = 1'b0;
        child_waddr    = top_node_reg;
        child_wdata    = {ctl.sym, idx};
        stk_waddr      = lvl_m1[SP_W-1:0];
        stk_wdata      = {top_node_reg, 1'b1};
        res.status     = ST_OK;
        res.symbol     = '0;

        unique case (ctl.cmd)
            CMD_LOAD:
            begin
                if (tree_done)
                begin
                    res.status = ST_OK;
                end
                else if (count_reg >= CNT_MAX || stack_full)
                begin
                    res.status = ST_OVERFLOW;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                    cur_next   = '0;
                    if (level_reg == '0)
                    begin
                        // Root node
                        root_sym_next = ctl.sym;
                        if (is_star)
                        begin
                            top_node_next  = idx;
                            top_ldone_next = 1'b0;
                            level_next     = LVL_W'(1);
                        end
                    end
                    else if (!top_ldone_reg)
                    begin
                        // Fill the left child; an internal child becomes the top and the old top is pushed below it
                        left_we        = ctl.commit;
                        top_ldone_next = 1'b1;
                        if (is_star)
                        begin
                            stk_we         = ctl.commit;
                            top_node_next  = idx;
                            top_ldone_next = 1'b0;
                            level_next     = level_reg + LVL_W'(1);
                        end
                    end
                    else
                    begin
                        // Fill the right child and retire the top
                        right_we = ctl.commit;
                        if (is_star)
                        begin
                            top_node_next  = idx;
                            top_ldone_next = 1'b0;
                        end
                        else
                        begin
                            level_next     = lvl_m1;
                            top_node_next  = stk_rdata[STK_W-1:1];
                            top_ldone_next = stk_rdata[0];
                        end
                    end
                end
            end
            CMD_DECODE:
            begin
                if (!tree_done)
                begin
                    res.status = ST_INCOMPLETE;
                end
                else if (cur_reg == '0 && root_sym_reg != SYM_INTERNAL)
                begin
                    // A tree that is a single leaf has no edges
                    res.status = ST_MISSING;
                end
                else if (child_sel[CHILD_W-1:NODE_W] != SYM_INTERNAL)
                begin
                    res.status = ST_DECODED;
                    res.symbol = child_sel[CHILD_W-1:NODE_W];
                    cur_next   = '0;
                end
                else
                begin
                    cur_next = child_sel[NODE_W-1:0];
                end
            end
            CMD_CLEAR:
            begin
                count_next = '0;
                level_next = '0;
                cur_next   = '0;
            end
            CMD_NONE:
            begin
                res.status = ST_OK;
            end
        endcase
    end

    // Commit the state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            level_reg     <= '0;
            cur_reg       <= '0;
            top_node_reg  <= '0;
            top_ldone_reg <= 1'b0;
            root_sym_reg  <= '0;
        end
        else if (ctl.commit)
        begin
            count_reg     <= count_next;
            level_reg     <= level_next;
            cur_reg       <= cur_next;
            top_node_reg  <= top_node_next;
            top_ldone_reg <= top_ldone_next;
            root_sym_reg  <= root_sym_next;
        end
    end

endmodule

[hdl/prefix_code_tree_decoder_top.sv]
// Top level of the prefix-code tree decoder: stream handshake, sequencer, output register.
// Depends on pctd_pkg, pctd_core and prefix_code_tree_decoder_top_defines.svh.
//
//  channel   direction  handshake                    payload
//  s_axis    in         s_axis_tvalid/s_axis_tready  tuser: command; tdata: tree_symbol, code_bit
//  m_axis    out        m_axis_tvalid/m_axis_tready  tuser: status; tdata: decoded_symbol
//
// On the accept edge the word is registered and the child and stack memories are read;
// in S_EXEC, once the output register is free, the update is committed and the result register loaded.
// The memory read data is registered; one word is in work at a time.
// A held result stalls the commit until m_axis_tready; a new word is taken meanwhile
// only after that commit.
// Reset (rst_n low) empties the tree; memory contents are not cleared.
`include "prefix_code_tree_decoder_top_defines.svh"

module prefix_code_tree_decoder_top
    import pctd_pkg::*;
#(
    parameter int MAX_NODES   = 256,
    parameter int STACK_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] tree_symbol, [8] code_bit, [15:9] zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] decoded_symbol
    output logic [2:0]  m_axis_tuser    // [2:0] status
);

    state_t     state_reg, state_next;
    cmd_t       cmd_reg;
    logic [7:0] sym_reg;
    logic       bit_reg;
    logic       out_valid_reg;
    logic [7:0] out_data_reg;
    logic [2:0] out_user_reg;
    logic       accept, out_free, commit;
    pctd_ctl_t  ctl;
    pctd_res_t  res;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        commit        = 1'b0;
        unique case (state_reg)
            S_IDLE: s_axis_tready = 1'b1;
            S_EXEC: commit        = out_free;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Hold the accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg <= CMD_NONE;
            sym_reg <= '0;
            bit_reg <= 1'b0;
        end
        else if (accept)
        begin
            cmd_reg <= cmd_t'(s_axis_tuser);
            sym_reg <= s_axis_tdata[7:0];
            bit_reg <= s_axis_tdata[8];
        end
    end

    assign ctl.issue    = accept;
    assign ctl.commit   = commit;
    assign ctl.cmd      = cmd_reg;
    assign ctl.sym      = sym_reg;
    assign ctl.code_bit = bit_reg;

    pctd_core #(
        .MAX_NODES   (MAX_NODES),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .res   (res)
    );

    // Output register: load on commit, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            out_data_reg <= res.symbol;
            out_user_reg <= res.status;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    // Checks
    `PCTD_CHECK_NEXT(a_commit_loads_result, commit, m_axis_tvalid, "commit did not load a result")
    `PCTD_CHECK_IMP(a_exec_blocks_input, state_reg == S_EXEC, !s_axis_tready, "word accepted while busy")
    `PCTD_CHECK_IMP(a_symbol_only_on_decode, m_axis_tvalid && m_axis_tuser != ST_DECODED, m_axis_tdata == 8'd0, "symbol set without decode")
    `PCTD_CHECK(a_status_range, !m_axis_tvalid || m_axis_tuser <= ST_OVERFLOW, "status code out of range")

endmodule
